>>> design/prdt_pkg.sv
// ----------------------------------------------------------------------------
// prdt_pkg
// shared types, constants and helpers of the pc reuse distance predictor table
// ----------------------------------------------------------------------------
package prdt_pkg;

    // default geometry
    localparam int PRDT_SETS      = 32;
    localparam int PRDT_WAYS      = 16;
    localparam int PRDT_PRED_BITS = 4;

    // fixed field widths
    localparam int CMD_W  = 1;
    localparam int PC_W   = 32;
    localparam int OBS_W  = 4;
    localparam int PRED_W = 4;
    localparam int CONF_W = 3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0]  CFG_SAFE_CONF = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAX_CONF  = 1'd1;
    localparam logic [CONF_W-1:0]     SAFE_CONF_RST = 3'd2;
    localparam logic [CONF_W-1:0]     MAX_CONF_RST  = 3'd3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MATCH,
        S_UPDATE
    } t_state;

    // floor(log2(sets)), at most 12
    function automatic int f_index_bits(input int sets);
        int b;
        b = 0;
        while (b < 12 && (1 << (b + 1)) <= sets) begin
            b++;
        end
        return b;
    endfunction

endpackage

>>> design/prdt_req_if.sv
// ----------------------------------------------------------------------------
// prdt_req_if
// request channel: command, pc and observed reuse distance
// ----------------------------------------------------------------------------
interface prdt_req_if;
    import prdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PC_W-1:0]   pc;
    logic [OBS_W-1:0]  observation;

    modport source (output valid, output cmd, output pc, output observation, input ready);
    modport sink   (input valid, input cmd, input pc, input observation, output ready);
endinterface

>>> design/prdt_rsp_if.sv
// ----------------------------------------------------------------------------
// prdt_rsp_if
// response channel: prediction and hit flag
// ----------------------------------------------------------------------------
interface prdt_rsp_if;
    import prdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [PRED_W-1:0] prediction;
    logic              hit;

    modport source (output valid, output prediction, output hit, input ready);
    modport sink   (input valid, input prediction, input hit, output ready);
endinterface

>>> design/pc_reuse_distance_predictor_table.sv
// ----------------------------------------------------------------------------
// pc_reuse_distance_predictor_table
// set-associative reuse distance predictor with per-set true lru stack,
// one memory row per set holding every way
// ----------------------------------------------------------------------------
// flow: an accepted request passes S_READ (row read), S_MATCH (tag match) and S_UPDATE
//   (modify, write back and response register load), which holds while an earlier
//   response is not taken; one request is in flight at a time, so the next is accepted in S_IDLE
// reset: after i_rst_n the table row memory is cleared one set per cycle,
//   all 2**floor(log2(SETS)) rows, while requests are held off; config
//   writes are taken throughout
// ----------------------------------------------------------------------------
module pc_reuse_distance_predictor_table #(
    parameter int SETS      = prdt_pkg::PRDT_SETS,
    parameter int WAYS      = prdt_pkg::PRDT_WAYS,
    parameter int PRED_BITS = prdt_pkg::PRDT_PRED_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prdt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    prdt_req_if.sink                        i_req,
    prdt_rsp_if.source                      o_rsp
);
    import prdt_pkg::*;

    localparam int IDX_BITS  = f_index_bits(SETS);
    localparam int ROWS      = 1 << IDX_BITS;
    localparam int ADDR_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int TAG_W     = PC_W - IDX_BITS;
    localparam int POS_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W   = TAG_W + PRED_BITS + CONF_W + POS_W;
    localparam int ROW_W     = WAYS * ENTRY_W;
    localparam logic [PC_W-1:0]   IDX_MASK = PC_W'((64'd1 << IDX_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);
    localparam logic [POS_W-1:0]  LRU_POS  = POS_W'(WAYS - 1);

    // state and config
    t_state              r_state, n_state;
    logic [CONF_W-1:0]   r_safe_conf, r_max_conf;
    logic [ADDR_W-1:0]   r_clr_cnt;

    // request registers
    logic [CMD_W-1:0]    r_cmd;
    logic [ADDR_W-1:0]   r_set;
    logic [TAG_W-1:0]    r_tag;
    logic [PRED_BITS-1:0] r_obs;

    // row memory and read data
    logic [ROW_W-1:0]    mem [ROWS];
    logic [ROW_W-1:0]    r_row;

    // match results
    logic                r_hit;
    logic [POS_W-1:0]    r_hway, r_vway;

    // response register
    logic                r_out_valid;
    logic [PRED_W-1:0]   r_out_pred;
    logic                r_out_hit;

    // unpacked row fields
    logic [TAG_W-1:0]     w_tag  [WAYS];
    logic [PRED_BITS-1:0] w_pred [WAYS];
    logic [CONF_W-1:0]    w_conf [WAYS];
    logic [POS_W-1:0]     w_pos  [WAYS];

    logic                 w_accept, w_fire, w_mem_we;
    logic [ADDR_W-1:0]    w_mem_addr;
    logic [ROW_W-1:0]     w_mem_wdata, w_upd_row, w_clr_row;
    logic                 w_found;
    logic [POS_W-1:0]     w_hway, w_vway;
    logic [PRED_W-1:0]    w_rsp_pred;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.prediction = r_out_pred;
    assign o_rsp.hit        = r_out_hit;

    assign w_accept = i_req.valid && (r_state == S_IDLE);

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            {w_tag[i], w_pred[i], w_conf[i], w_pos[i]} = r_row[i*ENTRY_W +: ENTRY_W];
        end
    end

    // tag match, lowest way wins; victim is the way at the lru position
    always_comb begin
        w_found = 1'b0;
        w_hway  = '0;
        w_vway  = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_tag[i] == r_tag) begin
                w_found = 1'b1;
                w_hway  = POS_W'(i);
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            if (w_pos[i] == LRU_POS) begin
                w_vway = POS_W'(i);
            end
        end
    end

    // modify the row
    always_comb begin
        logic [TAG_W-1:0]     u_tag  [WAYS];
        logic [PRED_BITS-1:0] u_pred [WAYS];
        logic [CONF_W-1:0]    u_conf [WAYS];
        logic [POS_W-1:0]     u_pos  [WAYS];
        logic [POS_W-1:0]     hpos;
        logic [PRED_BITS-1:0] hpred;
        logic [CONF_W-1:0]    hconf;

        hpos       = w_pos[r_hway];
        hpred      = w_pred[r_hway];
        hconf      = w_conf[r_hway];
        w_rsp_pred = '0;
        for (int i = 0; i < WAYS; i++) begin
            u_tag[i]  = w_tag[i];
            u_pred[i] = w_pred[i];
            u_conf[i] = w_conf[i];
            u_pos[i]  = w_pos[i];
        end

        if (r_hit) begin
            // move to front of the lru stack
            for (int i = 0; i < WAYS; i++) begin
                if (w_pos[i] < hpos) begin
                    u_pos[i] = w_pos[i] + POS_W'(1);
                end
            end
            u_pos[r_hway] = '0;
            if (r_cmd == CMD_LOOKUP) begin
                if (hconf >= r_safe_conf) begin
                    w_rsp_pred = PRED_W'(hpred);
                end
            end else if (hpred == r_obs) begin
                if (hconf < r_max_conf) begin
                    u_conf[r_hway] = hconf + CONF_W'(1);
                end
            end else if (hconf == '0) begin
                u_pred[r_hway] = r_obs;
            end else begin
                u_conf[r_hway] = hconf - CONF_W'(1);
            end
        end else if (r_cmd == CMD_UPDATE) begin
            // refill the lru way, age the rest
            for (int i = 0; i < WAYS; i++) begin
                if (w_pos[i] != LRU_POS) begin
                    u_pos[i] = w_pos[i] + POS_W'(1);
                end
            end
            u_tag[r_vway]  = r_tag;
            u_pred[r_vway] = r_obs;
            u_conf[r_vway] = '0;
            u_pos[r_vway]  = '0;
        end

        for (int i = 0; i < WAYS; i++) begin
            w_upd_row[i*ENTRY_W +: ENTRY_W] = {u_tag[i], u_pred[i], u_conf[i], u_pos[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_clr_row[i*ENTRY_W +: ENTRY_W] =
                {{(TAG_W + PRED_BITS + CONF_W){1'b0}}, POS_W'(i)};
        end
    end

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        w_fire      = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_set;
        w_mem_wdata = w_upd_row;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_cnt;
                w_mem_wdata = w_clr_row;
                if (r_clr_cnt == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                // hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    w_fire   = 1'b1;
                    w_mem_we = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_conf <= SAFE_CONF_RST;
            r_max_conf  <= MAX_CONF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAFE_CONF: r_safe_conf <= i_cfg_data;
                CFG_MAX_CONF:  r_max_conf  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.cmd;
            r_set <= ADDR_W'(i_req.pc & IDX_MASK);
            r_tag <= TAG_W'(i_req.pc >> IDX_BITS);
            r_obs <= PRED_BITS'(i_req.observation);
        end
        if (r_state == S_MATCH) begin
            r_hit  <= w_found;
            r_hway <= w_hway;
            r_vway <= w_vway;
        end
    end

    // row memory, registered read into r_row
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_wdata;
        end
        if (r_state == S_READ) begin
            r_row <= mem[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_pred <= w_rsp_pred;
            r_out_hit  <= r_hit;
        end
    end

endmodule

>>> tb/tb_pc_reuse_distance_predictor_table.sv
// ----------------------------------------------------------------------------
// tb_pc_reuse_distance_predictor_table
// self-checking bench for the pc reuse distance predictor table: a scoreboard
// class mirrors the tag, prediction, confidence and lru stack of every set,
// predicts the response of each accepted request and checks responses in
// order, while bursty requests, a stalling receiver and several confidence
// settings exercise hits, refills, training and saturation
// ----------------------------------------------------------------------------
module tb_pc_reuse_distance_predictor_table;
    timeunit 1ns;
    timeprecision 1ps;

    import prdt_pkg::*;

    localparam int IDX_W       = $clog2(PRDT_SETS);
    localparam int TAG_W       = PC_W - IDX_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 272;
    localparam int POOL        = 20;

    typedef struct packed {
        logic [PRED_W-1:0] prediction;
        logic              hit;
    } t_rsp_word;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE} t_ready_mode;

    class reuse_scoreboard;
        logic [TAG_W-1:0]  tag_mem  [PRDT_SETS][PRDT_WAYS];
        logic [PRED_W-1:0] pred_mem [PRDT_SETS][PRDT_WAYS];
        logic [CONF_W-1:0] conf_mem [PRDT_SETS][PRDT_WAYS];
        int unsigned       lru_pos  [PRDT_SETS][PRDT_WAYS];
        logic [CONF_W-1:0] safe_conf;
        logic [CONF_W-1:0] max_conf;
        t_rsp_word         pending_responses[$];
        int unsigned       mismatches;

        function new();
            for (int s = 0; s < PRDT_SETS; s++) begin
                for (int w = 0; w < PRDT_WAYS; w++) begin
                    tag_mem[s][w]  = '0;
                    pred_mem[s][w] = '0;
                    conf_mem[s][w] = '0;
                    lru_pos[s][w]  = w;
                end
            end
            safe_conf  = SAFE_CONF_RST;
            max_conf   = MAX_CONF_RST;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SAFE_CONF: safe_conf = data;
                CFG_MAX_CONF:  max_conf  = data;
                default: ;
            endcase
        endfunction

        // move a way to the top of its set's lru stack
        function void promote(int unsigned s, int unsigned w);
            int unsigned p;
            p = lru_pos[s][w];
            for (int i = 0; i < PRDT_WAYS; i++) begin
                if (lru_pos[s][i] < p) lru_pos[s][i]++;
            end
            lru_pos[s][w] = 0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [PC_W-1:0] pc,
                                   logic [OBS_W-1:0] obs_in);
            int unsigned       s;
            int unsigned       way;
            int unsigned       victim;
            logic [TAG_W-1:0]  tag;
            logic [PRED_W-1:0] obs;
            t_rsp_word         word;
            s    = pc[IDX_W-1:0];
            tag  = pc[PC_W-1:IDX_W];
            obs  = PRED_W'(obs_in & ((1 << PRDT_PRED_BITS) - 1));
            way  = PRDT_WAYS;
            word = '0;
            // lowest matching way wins, no valid bit
            for (int i = PRDT_WAYS - 1; i >= 0; i--) begin
                if (tag_mem[s][i] == tag) way = i;
            end
            if (way < PRDT_WAYS) begin
                word.hit = 1'b1;
                promote(s, way);
                if (cmd == CMD_LOOKUP) begin
                    if (conf_mem[s][way] >= safe_conf) word.prediction = pred_mem[s][way];
                end else if (pred_mem[s][way] == obs) begin
                    if (conf_mem[s][way] < max_conf) conf_mem[s][way]++;
                end else if (conf_mem[s][way] == 0) begin
                    pred_mem[s][way] = obs;
                end else begin
                    conf_mem[s][way]--;
                end
            end else if (cmd == CMD_UPDATE) begin
                // refill the lru way, everything else ages
                victim = PRDT_WAYS;
                for (int i = 0; i < PRDT_WAYS; i++) begin
                    if (lru_pos[s][i] == PRDT_WAYS - 1) victim = i;
                    else lru_pos[s][i]++;
                end
                if (victim >= PRDT_WAYS) victim = 0;
                tag_mem[s][victim]  = tag;
                pred_mem[s][victim] = obs;
                conf_mem[s][victim] = '0;
                lru_pos[s][victim]  = 0;
            end
            pending_responses.push_back(word);
        endfunction

        function void check_response(logic [PRED_W-1:0] prediction, logic hit);
            t_rsp_word want;
            if (pending_responses.size() == 0) begin
                $error("response with no request pending: prediction %0d hit %0d",
                       prediction, hit);
                mismatches++;
                return;
            end
            want = pending_responses.pop_front();
            if (prediction !== want.prediction) begin
                $error("prediction mismatch: expected %0d, actual %0d",
                       want.prediction, prediction);
                mismatches++;
            end
            if (hit !== want.hit) begin
                $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int unsigned           cycle_count = 0;

    logic [TAG_W-1:0] tag_pool [POOL];
    logic [OBS_W-1:0] fav_obs  [POOL];
    logic [IDX_W-1:0] hot_sets [4];

    reuse_scoreboard sb = new();

    prdt_req_if req_if ();
    prdt_rsp_if rsp_if ();

    pc_reuse_distance_predictor_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.prediction, rsp_if.hit);
        end
    end

    // receiver stalls: stretches of always ready, random ready, sparse ready
    initial begin
        t_ready_mode mode;
        int unsigned mode_left;
        int unsigned hold;
        rsp_if.ready = 1'b0;
        mode         = RDY_ALWAYS;
        mode_left    = 0;
        hold         = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                RDY_ALWAYS: rsp_if.ready <= 1'b1;
                RDY_RANDOM: rsp_if.ready <= ($urandom_range(0, 2) != 0);
                default: begin
                    if (hold != 0) begin
                        hold--;
                        rsp_if.ready <= 1'b0;
                    end else begin
                        rsp_if.ready <= 1'b1;
                        hold = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    // drive one word and hold it until accepted, valid stays high afterwards
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PC_W-1:0] pc,
                             input logic [OBS_W-1:0] obs);
        @(negedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.cmd         <= cmd;
        req_if.pc          <= pc;
        req_if.observation <= obs;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        sb.note_request(cmd, pc, obs);
    endtask

    task automatic hold_off(input int unsigned n);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CONF_W-1:0] safe, input logic [CONF_W-1:0] ceil);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SAFE_CONF;
        i_cfg_data <= safe;
        @(posedge i_clk);
        sb.set_register(CFG_SAFE_CONF, safe);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_CONF;
        i_cfg_data <= ceil;
        @(posedge i_clk);
        sb.set_register(CFG_MAX_CONF, ceil);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly a small tag pool on a few hot sets, so ways hit, train and get evicted
    task automatic random_item(output logic [CMD_W-1:0] cmd, output logic [PC_W-1:0] pc,
                               output logic [OBS_W-1:0] obs);
        int unsigned      r;
        int unsigned      k;
        logic [IDX_W-1:0] s;
        r   = $urandom_range(0, 99);
        k   = $urandom_range(0, POOL - 1);
        cmd = CMD_W'($urandom_range(0, 1));
        obs = ($urandom_range(0, 3) != 0) ? fav_obs[k] : OBS_W'($urandom_range(0, 15));
        if (r < 70) begin
            s  = hot_sets[$urandom_range(0, 3)];
            pc = {tag_pool[k], s};
        end else if (r < 88) begin
            s  = IDX_W'($urandom);
            pc = {tag_pool[k], s};
        end else begin
            pc  = $urandom;
            obs = OBS_W'($urandom);
        end
    endtask

    initial begin
        logic [CONF_W-1:0] safe_set [PHASES];
        logic [CONF_W-1:0] ceil_set [PHASES];
        logic [CMD_W-1:0]  cmd;
        logic [PC_W-1:0]   pc;
        logic [OBS_W-1:0]  obs;
        int unsigned       issued;
        int unsigned       burst;

        safe_set = '{3'd2, 3'd0, 3'd7, 3'd1, 3'd3, 3'd0, 3'd7};
        ceil_set = '{3'd3, 3'd0, 3'd7, 3'd5, 3'd1, 3'd7, 3'd0};
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        fav_obs[0]  = '0;
        fav_obs[1]  = '1;
        for (int k = 2; k < POOL; k++) begin
            tag_pool[k] = TAG_W'($urandom);
            fav_obs[k]  = OBS_W'($urandom_range(0, 15));
        end
        hot_sets[0] = '0;
        hot_sets[1] = '1;
        hot_sets[2] = IDX_W'($urandom);
        hot_sets[3] = IDX_W'($urandom);

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_SAFE_CONF;
        i_cfg_data         = '0;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_LOOKUP;
        req_if.pc          = '0;
        req_if.observation = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero tag hits way 0 from reset; all-ones tag misses, refills and trains
        send_word(CMD_LOOKUP, 32'h0000_0000, 4'd0);
        send_word(CMD_LOOKUP, 32'hffff_ffff, 4'd0);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd15);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd15);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd15);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd15);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd15);
        send_word(CMD_LOOKUP, 32'hffff_ffff, 4'd3);
        // wrong observations walk confidence down, then replace the prediction
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd0);
        send_word(CMD_LOOKUP, 32'hffff_ffff, 4'd0);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd0);
        send_word(CMD_LOOKUP, 32'hffff_ffff, 4'd0);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd0);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd0);
        send_word(CMD_UPDATE, 32'hffff_ffff, 4'd0);
        send_word(CMD_UPDATE, 32'h0000_0000, 4'd7);
        send_word(CMD_UPDATE, 32'h0000_001f, 4'd15);
        send_word(CMD_UPDATE, 32'hffff_ffe0, 4'd5);
        send_word(CMD_LOOKUP, 32'h0000_0020, 4'd15);
        send_word(CMD_LOOKUP, 32'h8000_0001, 4'd8);
        send_word(CMD_UPDATE, 32'h5555_5555, 4'd10);
        send_word(CMD_UPDATE, 32'haaaa_aaaa, 4'd5);
        send_word(CMD_LOOKUP, 32'h0000_0000, 4'd0);
        hold_off(2);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                write_config(safe_set[ph], ceil_set[ph]);
            end
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++) begin
                    random_item(cmd, pc, obs);
                    send_word(cmd, pc, obs);
                    issued++;
                end
                // some bursts run straight into the next one
                if ($urandom_range(0, 4) != 0) hold_off($urandom_range(1, 6));
            end
            hold_off(1);
        end

        drain();
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> pc_reuse_distance_predictor_table.f
design/prdt_pkg.sv
design/prdt_req_if.sv
design/prdt_rsp_if.sv
design/pc_reuse_distance_predictor_table.sv
tb/tb_pc_reuse_distance_predictor_table.sv
